/* sv/epc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants for the EPROM programmer card
// Bus cycle codes, chip codes, register indexes and the word structs.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int unsigned SmallSocketBytesDef = 1024;
  localparam int unsigned LargeSocketBytesDef = 2048;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned OffW    = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 4;

  localparam logic [1:0] OP_IO_WRITE  = 2'd0;
  localparam logic [1:0] OP_MEM_READ  = 2'd1;
  localparam logic [1:0] OP_MEM_WRITE = 2'd2;
  localparam logic [1:0] OP_IO_READ   = 2'd3;

  localparam logic [1:0] CHIP_NONE  = 2'd0;
  localparam logic [1:0] CHIP_SMALL = 2'd1;
  localparam logic [1:0] CHIP_LARGE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_CARD_ENABLED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PORT_NIBBLE  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_BLOCK = 2'd2;

  localparam logic [DataW-1:0] ERASED_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]       op;
    logic [AddrW-1:0] bus_address;
    logic [DataW-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic             claimed;
    logic [DataW-1:0] read_data;
  } out_word_t;

endpackage
`default_nettype wire

/* sv/eprom_programmer_card.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eprom_programmer_card: bus-attached EPROM programmer with two sockets
// Decodes host bus cycles: control port writes arm the card, window reads
// return socket bytes, armed window writes burn (AND) into the socket.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                 word
//  in       in   in_valid_i / in_ready_o    epc_pkg::in_word_t
//  out      out  out_valid_o / out_ready_i  epc_pkg::out_word_t
//  cfg      in   cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
//  Each word is handled in order: socket read on acceptance, then
//  decode and burn write-back from the registered word and read byte.
//  After reset a clearing pass writes 0xFF over the sockets, one byte a
//  cycle, up to max(SMALL_SOCKET_BYTES, LARGE_SOCKET_BYTES) bytes; no word
//  is taken meanwhile, config writes are. A stalled result holds the word
//  in the decode stage; a new word is taken once that stage is empty.
// ----------------------------------------------------------------------------
module eprom_programmer_card #(
  parameter int unsigned SMALL_SOCKET_BYTES = epc_pkg::SmallSocketBytesDef,
  parameter int unsigned LARGE_SOCKET_BYTES = epc_pkg::LargeSocketBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire epc_pkg::in_word_t            in_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output epc_pkg::out_word_t                out_word_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [epc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [epc_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int unsigned MaxBytes = (SMALL_SOCKET_BYTES > LARGE_SOCKET_BYTES) ?
                                     SMALL_SOCKET_BYTES : LARGE_SOCKET_BYTES;
  localparam int unsigned SaW  = $clog2(SMALL_SOCKET_BYTES);
  localparam int unsigned LaW  = $clog2(LARGE_SOCKET_BYTES);
  localparam int unsigned CntW = $clog2(MaxBytes);
  localparam int unsigned CmpW = epc_pkg::OffW + 1;

  localparam logic [CmpW-1:0] SmallLim = CmpW'(SMALL_SOCKET_BYTES);
  localparam logic [CmpW-1:0] LargeLim = CmpW'(LARGE_SOCKET_BYTES);
  localparam logic [CntW-1:0] CntLast  = CntW'(MaxBytes - 1);

  logic [epc_pkg::DataW-1:0] small_mem [SMALL_SOCKET_BYTES];
  logic [epc_pkg::DataW-1:0] large_mem [LARGE_SOCKET_BYTES];

  logic       enabled_q;
  logic [3:0] nibble_q;
  logic [3:0] window_q;
  logic       armed_q, armed_d;
  logic [1:0] chip_q, chip_d;
  logic       clr_q;
  logic [CntW-1:0] cnt_q;
  logic       busy_q;
  epc_pkg::in_word_t  item_q;
  logic [epc_pkg::DataW-1:0] srd_q, lrd_q;
  logic       out_valid_q;
  epc_pkg::out_word_t out_q;
  epc_pkg::out_word_t res;

  logic accept, done;
  logic [epc_pkg::OffW-1:0] in_off, off;
  logic [CmpW-1:0] off_x;
  logic in_window, small_ok, large_ok;
  logic burn_s, burn_l;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q && !clr_q;
  assign done       = busy_q && (!out_valid_q || out_ready_i);
  assign in_off     = in_word_i.bus_address[epc_pkg::OffW-1:0];
  assign off        = item_q.bus_address[epc_pkg::OffW-1:0];
  assign off_x      = CmpW'(off);
  assign small_ok   = off_x < SmallLim;
  assign large_ok   = off_x < LargeLim;
  assign in_window  = item_q.bus_address[epc_pkg::AddrW-1:epc_pkg::OffW] == window_q;

  always_comb begin
    res       = '{claimed: 1'b0, read_data: epc_pkg::ERASED_BYTE};
    armed_d   = armed_q;
    chip_d    = chip_q;
    burn_s    = 1'b0;
    burn_l    = 1'b0;
    if (enabled_q) begin
      unique case (item_q.op)
        epc_pkg::OP_IO_WRITE: begin
          if (item_q.bus_address[7:0] == {nibble_q, 4'b0000}) begin
            res.claimed = 1'b1;
            armed_d     = 1'b1;
            if (item_q.write_data[0]) chip_d = epc_pkg::CHIP_SMALL;
            else if (item_q.write_data[1]) chip_d = epc_pkg::CHIP_LARGE;
            else chip_d = epc_pkg::CHIP_NONE;
          end
        end
        epc_pkg::OP_MEM_READ: begin
          if (in_window) begin
            res.claimed = 1'b1;
            armed_d     = 1'b0;
            if (chip_q == epc_pkg::CHIP_LARGE) begin
              if (large_ok) res.read_data = lrd_q;
            end else if (small_ok) begin
              res.read_data = srd_q;
            end
          end
        end
        epc_pkg::OP_MEM_WRITE: begin
          if (in_window) begin
            res.claimed = 1'b1;
            if (armed_q) begin
              if (chip_q == epc_pkg::CHIP_LARGE) burn_l = large_ok;
              else if (chip_q != epc_pkg::CHIP_NONE) burn_s = small_ok;
            end
          end
        end
        epc_pkg::OP_IO_READ: ;
        default: ;
      endcase
    end
  end

  // sockets: clearing pass, else burn write-back; read on acceptance
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      if (CmpW'(cnt_q) < SmallLim) small_mem[cnt_q[SaW-1:0]] <= epc_pkg::ERASED_BYTE;
    end else if (done && burn_s) begin
      small_mem[off[SaW-1:0]] <= srd_q & item_q.write_data;
    end
    if (accept) srd_q <= small_mem[in_off[SaW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      if (CmpW'(cnt_q) < LargeLim) large_mem[cnt_q[LaW-1:0]] <= epc_pkg::ERASED_BYTE;
    end else if (done && burn_l) begin
      large_mem[off[LaW-1:0]] <= lrd_q & item_q.write_data;
    end
    if (accept) lrd_q <= large_mem[in_off[LaW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_word_i;
    if (done) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      nibble_q    <= '0;
      window_q    <= '0;
      armed_q     <= 1'b0;
      chip_q      <= epc_pkg::CHIP_SMALL;
      clr_q       <= 1'b1;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          epc_pkg::REG_CARD_ENABLED: enabled_q <= cfg_wdata_i[0];
          epc_pkg::REG_PORT_NIBBLE:  nibble_q  <= cfg_wdata_i;
          epc_pkg::REG_WINDOW_BLOCK: window_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (clr_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) clr_q <= 1'b0;
      end
      if (accept) busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
      if (done) begin
        armed_q     <= armed_d;
        chip_q      <= chip_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !busy_q && !out_valid_q)
    else $error("word in flight during clearing pass");

  a_burn_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burn_s || burn_l) |-> armed_q && enabled_q && (item_q.op == epc_pkg::OP_MEM_WRITE))
    else $error("burn without armed memory write");

  a_read_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && res.claimed && (item_q.op == epc_pkg::OP_MEM_READ)) |=> !armed_q)
    else $error("window read left card armed");

  a_unclaimed_ff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.claimed) |-> (out_word_o.read_data == epc_pkg::ERASED_BYTE))
    else $error("unclaimed word carries data");
`endif

endmodule
`default_nettype wire
